### rtl/generational_slot_allocator_macros.svh
// Assertion macros for the generational slot allocator.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define GSA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("allocator assertion failed");
// Next-cycle implication, checked outside reset.
`define GSA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("allocator assertion failed");
`else
`define GSA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define GSA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

### rtl/gsa_pkg.sv
// Shared types and codes of the generational slot allocator.
package gsa_pkg;

  // item kinds
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_CHECK   = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_DEV_FAULT   = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE    = 3'd2;
  localparam logic [2:0] ST_OVER_BUDGET = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ID = 2'd0;
  localparam logic [1:0] CFG_DEV_FAULT = 2'd1;
  localparam logic [1:0] CFG_BUDGET    = 2'd2;

  localparam int unsigned BUDGET_RESET = 134217728;
  localparam int unsigned COST_W       = 26;
  localparam int unsigned BYTES_W      = 28;

  typedef struct packed {
    logic [1:0]  kind;
    logic [17:0] vertex_count;
    logic [19:0] index_count;
    logic [31:0] handle_device;
    logic [15:0] handle_slot;
    logic [31:0] handle_generation;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        owned;
    logic [31:0] out_device;
    logic [9:0]  out_slot;
    logic [31:0] out_generation;
    logic [10:0] live_meshes;
    logic [27:0] used_bytes;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]        kind;
    logic              bad_size;
    logic [COST_W-1:0] cost;
    logic [31:0]       hdev;
    logic [15:0]       hslot;
    logic [31:0]       hgen;
  } cmd_t;

endpackage

### rtl/gsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/gsa_front.sv
// Front part: takes items, computes cost and size check, queues them.
module gsa_front #(
  parameter int unsigned MAX_VERTICES = 250000,
  parameter int unsigned MAX_INDICES  = 750000,
  parameter int unsigned VERTEX_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  gsa_pkg::in_item_t in_item,
  output logic              cmd_valid,
  output gsa_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);
  import gsa_pkg::*;

  // true when x is a multiple of 3 (base-4 digit sums, 4 = 1 mod 3)
  function automatic logic mult3(input logic [19:0] x);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = '0;
    for (int i = 0; i < 10; i++) begin
      s1 = s1 + 5'(x[2*i +: 2]);
    end
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (s3 == 3'd0) || (s3 == 3'd3);
  endfunction

  cmd_t       q_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  cmd_t       cls;
  logic       do_push;

  // classify the incoming item
  always_comb begin
    cls.kind     = in_item.kind;
    cls.cost     = COST_W'(in_item.vertex_count) * COST_W'(VERTEX_BYTES)
                 + COST_W'({in_item.index_count, 2'b00});
    cls.bad_size = (in_item.vertex_count == '0)
                || (in_item.vertex_count > 18'(MAX_VERTICES))
                || (in_item.index_count == '0)
                || (in_item.index_count > 20'(MAX_INDICES))
                || !mult3(in_item.index_count);
    cls.hdev     = in_item.handle_device;
    cls.hslot    = in_item.handle_slot;
    cls.hgen     = in_item.handle_generation;
  end

  assign full      = (cnt_r == 2'd2);
  assign do_push   = push && !full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rptr_r];

  // two-entry queue toward the back part
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        q_r[wptr_r] <= cls;
        wptr_r      <= !wptr_r;
      end
      if (cmd_pop) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(cmd_pop);
    end
  end
endmodule

### rtl/gsa_back.sv
// Back part: slot table, free-slot bitmap scan and result register.
module gsa_back #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  gsa_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic [31:0]        device_id,
  input  logic               dev_fault,
  input  logic [27:0]        budget,
  output logic               empty,
  input  logic               pop,
  output gsa_pkg::out_item_t out_item
);
  import gsa_pkg::*;

  localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CHUNK  = 64;
  localparam int unsigned NCH    = (MAX_SLOTS + CHUNK - 1) / CHUNK;
  localparam int unsigned CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned PAD_W  = $clog2(NCH * CHUNK);

  typedef struct packed {
    logic               live;
    logic [31:0]        gen;
    logic [BYTES_W-1:0] bytes;
  } slot_ent_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_ARD, S_HRD} state_t;

  function automatic logic [5:0] lowest(input logic [CHUNK-1:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [CH_W-1:0]     chunk_r, chunk_nxt;
  logic [PAD_W-1:0]    pick_r, pick_nxt;
  logic [CNT_W-1:0]    in_use_r, in_use_nxt;
  logic [CNT_W-1:0]    live_r, live_nxt;
  logic [BYTES_W-1:0]  total_r, total_nxt;
  logic [NCH*CHUNK-1:0] reuse_r;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
  slot_ent_t           ram_wdata, ram_rdata;
  logic                set_en, set_val;
  logic [PAD_W-1:0]    set_idx;

  logic [CHUNK-1:0]    chunk_bits;
  logic [PAD_W-1:0]    hit_pick;
  logic                fin, f_owned, f_new;
  logic [2:0]          f_status;
  logic [31:0]         f_gen, gen_inc;
  logic [SLOT_W-1:0]   f_slot;
  logic                over;

  gsa_ram #(.WIDTH($bits(slot_ent_t)), .DEPTH(MAX_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign chunk_bits = reuse_r[chunk_r * CHUNK +: CHUNK];
  assign hit_pick   = PAD_W'({chunk_r, lowest(chunk_bits)});
  assign over       = (29'(total_r) + 29'(cmd.cost)) > 29'(budget);
  assign gen_inc    = ram_rdata.gen + 32'd1;
  assign empty      = !out_valid_r;
  assign out_item   = out_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    chunk_nxt = chunk_r;
    pick_nxt  = pick_r;
    in_use_nxt = in_use_r;
    live_nxt  = live_r;
    total_nxt = total_r;
    out_nxt   = out_r;
    out_valid_nxt = out_valid_r && !pop;
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = SLOT_W'(pick_r);
    ram_wdata = '0;
    ram_raddr = SLOT_W'(pick_r);
    set_en    = 1'b0;
    set_val   = 1'b0;
    set_idx   = pick_r;
    fin       = 1'b0;
    f_owned   = 1'b0;
    f_new     = 1'b0;
    f_status  = ST_OK;
    f_gen     = '0;
    f_slot    = SLOT_W'(pick_r);

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && !out_valid_r) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          unique case (cmd.kind)
            KIND_ALLOC: begin
              if (dev_fault) begin
                fin = 1'b1;  f_status = ST_DEV_FAULT;
              end else if (cmd.bad_size) begin
                fin = 1'b1;  f_status = ST_BAD_SIZE;
              end else if (over) begin
                fin = 1'b1;  f_status = ST_OVER_BUDGET;
              end else begin
                chunk_nxt = '0;
                state_nxt = S_SCAN;
              end
            end
            KIND_RELEASE, KIND_CHECK: begin
              if (cmd.hdev == device_id && cmd.hslot < 16'(in_use_r)) begin
                ram_raddr = SLOT_W'(cmd.hslot);
                state_nxt = S_HRD;
              end else begin
                fin = 1'b1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        if (chunk_bits != '0) begin
          pick_nxt  = hit_pick;
          ram_raddr = SLOT_W'(hit_pick);
          state_nxt = S_ARD;
        end else if (chunk_r == CH_W'(NCH - 1)) begin
          state_nxt = S_IDLE;
          fin       = 1'b1;
          if (in_use_r == CNT_W'(MAX_SLOTS)) begin
            f_status = ST_TABLE_FULL;
          end else begin
            // append a fresh slot at generation zero
            ram_we     = 1'b1;
            ram_waddr  = SLOT_W'(in_use_r);
            ram_wdata  = '{live: 1'b1, gen: '0, bytes: BYTES_W'(cmd_r.cost)};
            in_use_nxt = in_use_r + 1'b1;
            live_nxt   = live_r + 1'b1;
            total_nxt  = total_r + BYTES_W'(cmd_r.cost);
            f_new      = 1'b1;
            f_slot     = SLOT_W'(in_use_r);
          end
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end
      S_ARD: begin
        // reuse a freed slot, keeping its generation
        ram_we    = 1'b1;
        ram_wdata = '{live: 1'b1, gen: ram_rdata.gen, bytes: BYTES_W'(cmd_r.cost)};
        set_en    = 1'b1;
        live_nxt  = live_r + 1'b1;
        total_nxt = total_r + BYTES_W'(cmd_r.cost);
        f_new     = 1'b1;
        f_gen     = ram_rdata.gen;
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      S_HRD: begin
        f_owned   = ram_rdata.live && (ram_rdata.gen == cmd_r.hgen);
        fin       = 1'b1;
        state_nxt = S_IDLE;
        if (f_owned && cmd_r.kind == KIND_RELEASE) begin
          ram_we    = 1'b1;
          ram_waddr = SLOT_W'(cmd_r.hslot);
          ram_wdata = '{live: 1'b0, gen: gen_inc, bytes: ram_rdata.bytes};
          set_en    = 1'b1;
          set_idx   = PAD_W'(cmd_r.hslot);
          set_val   = (gen_inc != '1);
          live_nxt  = live_r - 1'b1;
          total_nxt = total_r - ram_rdata.bytes;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // build the result
    if (fin) begin
      out_valid_nxt          = 1'b1;
      out_nxt.status         = f_status;
      out_nxt.owned          = f_owned;
      out_nxt.out_device     = f_new ? device_id : '0;
      out_nxt.out_slot       = f_new ? 10'(f_slot) : '0;
      out_nxt.out_generation = f_new ? f_gen : '0;
      out_nxt.live_meshes    = 11'(live_nxt);
      out_nxt.used_bytes     = total_nxt;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      live_r      <= '0;
      total_r     <= '0;
      reuse_r     <= '0;
      out_valid_r <= 1'b0;
      chunk_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      live_r      <= live_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      chunk_r     <= chunk_nxt;
      if (set_en) begin
        reuse_r[set_idx] <= set_val;
      end
    end
    cmd_r  <= cmd_nxt;
    pick_r <= pick_nxt;
    out_r  <= out_nxt;
  end
endmodule

### rtl/generational_slot_allocator.sv
// Generational slot allocator: handle table with generations and a byte budget.
// An allocate item is checked when accepted, then the free-slot bitmap is scanned
// one 64-slot chunk at a time up to the chunk that holds the lowest reusable slot,
// and that freed slot's entry is read from the slot table and rewritten; with
// nothing to reuse the scan covers all ceil(MAX_SLOTS/64) chunks and a fresh slot
// is appended unless the table is full. Release and check items whose device
// matches and whose slot is in range first read the single slot table, which has
// registered read data. Items that fail early (device fault, bad size, over
// budget, wrong device or slot out of range, unused kind) get their result
// straight from the accepting state. A result waiting to be popped holds the back
// part; a two-entry queue between the classifying front and the back lets
// items be pushed meanwhile. Slots past the append point are never read, so
// the table needs no clearing pass after reset.
`include "generational_slot_allocator_macros.svh"
module generational_slot_allocator #(
  parameter int unsigned MAX_SLOTS    = 1024,
  parameter int unsigned MAX_VERTICES = 250000,
  parameter int unsigned MAX_INDICES  = 750000,
  parameter int unsigned VERTEX_BYTES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  gsa_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output gsa_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import gsa_pkg::*;

  logic [31:0] device_id_r;
  logic        dev_fault_r;
  logic [27:0] budget_r;
  logic        cmd_valid, cmd_pop;
  cmd_t        cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= '0;
      dev_fault_r <= 1'b0;
      budget_r    <= 28'(BUDGET_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_ID: device_id_r <= cfg_data;
        CFG_DEV_FAULT: dev_fault_r <= cfg_data[0];
        CFG_BUDGET:    budget_r    <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  gsa_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_INDICES  (MAX_INDICES),
    .VERTEX_BYTES (VERTEX_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  gsa_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .device_id   (device_id_r),
    .dev_fault   (dev_fault_r),
    .budget      (budget_r),
    .empty       (empty),
    .pop         (pop),
    .out_item    (out_item)
  );

  // a failed or non-allocating result never carries a new handle
  `GSA_ASSERT_IMP(a_fail_no_handle, clk, rst_n, !empty && out_item.status != ST_OK, out_item.out_generation == '0 && out_item.out_device == '0 && !out_item.owned)
  // ownership is only reported with ok status
  `GSA_ASSERT_IMP(a_owned_ok, clk, rst_n, !empty && out_item.owned, out_item.status == ST_OK && out_item.out_slot == '0)
  // live count never exceeds the table size
  `GSA_ASSERT_IMP(a_live_bound, clk, rst_n, !empty, 32'(out_item.live_meshes) <= MAX_SLOTS)
  // a popped result leaves the output empty while no command is waiting
  `GSA_ASSERT_NXT(a_pop_frees, clk, rst_n, !empty && pop && !cmd_valid, empty)
endmodule

### dv/generational_slot_allocator_tb.sv
// Self-checking testbench of the generational slot allocator.
module generational_slot_allocator_tb;
  import gsa_pkg::*;

  localparam int unsigned SLOTS     = 1024;
  localparam int unsigned VERT_MAX  = 250000;
  localparam int unsigned IDX_MAX   = 750000;
  localparam int unsigned DRAIN_CYC = 40;

  typedef struct packed {
    logic [31:0] dev;
    logic [15:0] slot;
    logic [31:0] gen;
  } handle_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // shadow copy of the allocator state
  logic        sh_live [SLOTS];
  logic [31:0] sh_gen [SLOTS];
  logic [23:0] sh_bytes [SLOTS];
  int unsigned sh_in_use, sh_live_cnt;
  logic [27:0] sh_total;
  logic [31:0] sh_dev_id;
  logic        sh_dev_fault;
  logic [27:0] sh_budget;

  in_item_t    pending_items [$];
  out_item_t   expected_results [$];
  handle_t     handle_pool [$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        recv_hold = 1'b0;
  int          errors = 0;
  int          n_alloc_ok = 0, n_full = 0, n_budget = 0, n_release = 0;

  generational_slot_allocator i_dut (
    .clk, .rst_n, .push, .full, .in_item, .empty, .pop, .out_item,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  function automatic logic is_owner(logic [31:0] d, logic [15:0] s, logic [31:0] g);
    return d == sh_dev_id && s < sh_in_use && s < SLOTS && sh_live[s[9:0]] &&
           sh_gen[s[9:0]] == g;
  endfunction

  // expected result of one item; updates the shadow state
  function automatic out_item_t allocate_or_release(in_item_t it);
    out_item_t r;
    logic [63:0] cost;
    int pick;
    handle_t h;
    logic [9:0] hs;
    r = '0;
    hs = it.handle_slot[9:0];
    cost = 64'(it.vertex_count) * 32 + 64'(it.index_count) * 4;
    if (it.kind == KIND_ALLOC) begin
      if (sh_dev_fault) begin
        r.status = ST_DEV_FAULT;
      end else if (it.vertex_count == 0 || it.vertex_count > VERT_MAX ||
                   it.index_count == 0 || it.index_count > IDX_MAX ||
                   it.index_count % 3 != 0) begin
        r.status = ST_BAD_SIZE;
      end else if (64'(sh_total) + cost > 64'(sh_budget)) begin
        r.status = ST_OVER_BUDGET;
        n_budget++;
      end else begin
        pick = -1;
        for (int i = 0; i < sh_in_use; i++) begin
          if (pick < 0 && !sh_live[i] && sh_gen[i] != 32'hFFFF_FFFF) pick = i;
        end
        if (pick < 0) begin
          if (sh_in_use >= SLOTS) begin
            r.status = ST_TABLE_FULL;
            n_full++;
          end else begin
            pick = sh_in_use;
            sh_gen[pick] = '0;
            sh_in_use++;
          end
        end
        if (r.status == ST_OK) begin
          sh_live[pick] = 1'b1;
          sh_bytes[pick] = cost[23:0];
          sh_total = sh_total + cost[27:0];
          sh_live_cnt++;
          r.out_device = sh_dev_id;
          r.out_slot = pick[9:0];
          r.out_generation = sh_gen[pick];
          h.dev = sh_dev_id;
          h.slot = 16'(pick);
          h.gen = sh_gen[pick];
          handle_pool.push_back(h);
          n_alloc_ok++;
        end
      end
    end else if (it.kind == KIND_RELEASE) begin
      if (is_owner(it.handle_device, it.handle_slot, it.handle_generation)) begin
        r.owned = 1'b1;
        sh_total = sh_total - 28'(sh_bytes[hs]);
        sh_live_cnt--;
        sh_live[hs] = 1'b0;
        sh_gen[hs] = sh_gen[hs] + 32'd1;
        n_release++;
      end
    end else if (it.kind == KIND_CHECK) begin
      r.owned = is_owner(it.handle_device, it.handle_slot, it.handle_generation);
    end
    r.live_meshes = sh_live_cnt[10:0];
    r.used_bytes = sh_total;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // acceptance, prediction, configuration shadow and result checking
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_ID: sh_dev_id = cfg_data;
        CFG_DEV_FAULT: sh_dev_fault = cfg_data[0];
        CFG_BUDGET:    sh_budget = cfg_data[27:0];
        default: ;
      endcase
    end
    if (rst_n && push && !full) begin
      expected_results.push_back(allocate_or_release(in_item));
      void'(pending_items.pop_front());
    end
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: actual %0h", $time, out_item);
      end else begin
        e = expected_results.pop_front();
        check_field("status", e.status, out_item.status);
        check_field("owned", e.owned, out_item.owned);
        check_field("out_device", e.out_device, out_item.out_device);
        check_field("out_slot", e.out_slot, out_item.out_slot);
        check_field("out_generation", e.out_generation, out_item.out_generation);
        check_field("live_meshes", e.live_meshes, out_item.live_meshes);
        check_field("used_bytes", e.used_bytes, out_item.used_bytes);
      end
    end
  end

  // sender: offers the oldest pending item
  always @(negedge clk) begin
    if (rst_n && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      push <= 1'b1;
      in_item <= pending_items[0];
    end else begin
      push <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    pop <= rst_n && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off, counted here
  always @(posedge recv_hold) begin
    repeat (400) @(negedge clk);
    recv_hold = 1'b0;
  end

  task automatic add_item(in_item_t it);
    while (pending_items.size() >= 4) @(posedge clk);
    #1;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || push || expected_results.size() > 0 || recv_hold)
      @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t mesh_item(logic [17:0] vc, logic [19:0] ic);
    in_item_t it;
    it = '0;
    it.kind = KIND_ALLOC;
    it.vertex_count = vc;
    it.index_count = ic;
    return it;
  endfunction

  function automatic in_item_t handle_item(logic [1:0] k, handle_t h);
    in_item_t it;
    it = '0;
    it.kind = k;
    it.handle_device = h.dev;
    it.handle_slot = h.slot;
    it.handle_generation = h.gen;
    return it;
  endfunction

  // random item: mostly well-formed, some noise
  function automatic in_item_t random_item(bit small_only);
    in_item_t it;
    handle_t h;
    int k, pick, roll;
    it = in_item_t'({$urandom, $urandom, $urandom, 24'($urandom)});
    if ($urandom_range(99) < 12) return it;
    roll = $urandom_range(99);
    if (roll < 45) begin
      it = mesh_item(18'($urandom_range(1, 64)), 20'(3 * $urandom_range(1, 40)));
      if (!small_only && $urandom_range(19) == 0) begin
        it.vertex_count = 18'(VERT_MAX);
        it.index_count = 20'(IDX_MAX);
      end
      if ($urandom_range(9) == 0) it.index_count = it.index_count + 20'd1;
    end else if (roll < 95 && handle_pool.size() > 0) begin
      k = (roll < 75) ? KIND_RELEASE : KIND_CHECK;
      pick = $urandom_range(handle_pool.size() - 1);
      h = handle_pool[pick];
      if (k == KIND_RELEASE) handle_pool.delete(pick);
      case ($urandom_range(7))
        0: h.dev = h.dev ^ (32'd1 << $urandom_range(31));
        1: h.gen = h.gen + 32'd1;
        2: h.slot = h.slot ^ (16'd1 << $urandom_range(15));
        default: ;
      endcase
      it = handle_item(2'(k), h);
    end else begin
      it.kind = KIND_NONE;
    end
    return it;
  endfunction

  task automatic random_phase(int n, int s_idle, int r_idle, bit small_only);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n; i++) add_item(random_item(small_only));
    wait_idle();
  endtask

  // stimulus sequence
  initial begin
    handle_t h;
    for (int i = 0; i < SLOTS; i++) begin
      sh_live[i] = 1'b0;
      sh_gen[i] = '0;
      sh_bytes[i] = '0;
    end
    sh_in_use = 0;
    sh_live_cnt = 0;
    sh_total = '0;
    sh_dev_id = '0;
    sh_dev_fault = 1'b0;
    sh_budget = 28'(BUDGET_RESET);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    write_reg(CFG_DEVICE_ID, $urandom);
    write_reg(CFG_DEV_FAULT, 32'd0);
    write_reg(CFG_BUDGET, BUDGET_RESET);

    // directed: size limits, largest mesh, handles
    add_item(mesh_item(18'd1, 20'd3));
    add_item(mesh_item(18'(VERT_MAX), 20'(IDX_MAX)));
    add_item(mesh_item(18'd0, 20'd3));
    add_item(mesh_item(18'(VERT_MAX + 1), 20'd3));
    add_item(mesh_item(18'h3FFFF, 20'd3));
    add_item(mesh_item(18'd5, 20'd0));
    add_item(mesh_item(18'd5, 20'(IDX_MAX + 3)));
    add_item(mesh_item(18'd5, 20'd7));
    add_item(mesh_item(18'd5, 20'hFFFFF));
    wait_idle();
    h = handle_pool[0];
    add_item(handle_item(KIND_CHECK, h));
    add_item(handle_item(KIND_RELEASE, h));
    add_item(handle_item(KIND_CHECK, h));
    add_item(handle_item(KIND_RELEASE, h));
    add_item(handle_item(KIND_CHECK, '{dev: ~h.dev, slot: h.slot, gen: h.gen}));
    add_item(handle_item(KIND_CHECK, '{dev: h.dev, slot: 16'hFFFF, gen: h.gen}));
    add_item(handle_item(KIND_NONE, h));
    add_item(mesh_item(18'd2, 20'd6));
    wait_idle();
    handle_pool.delete(0);

    // device fault, then back
    write_reg(CFG_DEV_FAULT, 32'd1);
    random_phase(30, 0, 0, 1'b1);
    write_reg(CFG_DEV_FAULT, 32'd0);

    random_phase(300, 0, 0, 1'b0);
    random_phase(200, 88, 0, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 88;
    recv_hold = 1'b1;
    for (int i = 0; i < 200; i++) add_item(random_item(1'b0));
    wait_idle();
    random_phase(200, 28, 28, 1'b0);

    // budget extremes: zero, below the live total, then tight
    write_reg(CFG_BUDGET, 32'd0);
    random_phase(40, 28, 28, 1'b1);
    write_reg(CFG_BUDGET, 32'(sh_total >> 1));
    random_phase(40, 0, 0, 1'b1);
    write_reg(CFG_BUDGET, 32'(sh_total) + 32'd2000);
    random_phase(60, 0, 28, 1'b1);
    write_reg(CFG_DEVICE_ID, 32'hFFFF_FFFF);
    write_reg(CFG_BUDGET, BUDGET_RESET);

    // fill the table until it reports full, then release some
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sh_in_use + 8 < SLOTS || n_full < 4) begin
      add_item(mesh_item(18'd1, 20'd3));
      if (n_full >= 4) break;
    end
    wait_idle();
    random_phase(150, 28, 28, 1'b1);
    write_reg(CFG_DEVICE_ID, 32'd0);
    random_phase(60, 0, 0, 1'b1);

    $display("covered %0d good allocations, %0d releases, %0d over-budget, %0d table-full",
             n_alloc_ok, n_release, n_budget, n_full);
    $display("peak slots used %0d of %0d across several idle and stall mixes", sh_in_use, SLOTS);
    if (errors == 0) begin
      $display("PASS generational_slot_allocator");
    end else begin
      $display("FAIL generational_slot_allocator");
    end
    $finish;
  end

  // run limit
  initial begin
    #30000000;
    $display("FAIL generational_slot_allocator");
    $finish;
  end

endmodule
